// ----- hdl/iate_pkg.sv -----
// Package for the indexed array table engine: command and status codes,
// sequencer states, table capacity and shared types. No dependencies.
package iate_pkg;

    // Table capacity; the index fields on the ports are sized for it
    localparam int DEPTH = 64;

    typedef enum logic [3:0] {
        CMD_INSERT   = 4'd0,
        CMD_UPDATE   = 4'd1,
        CMD_REMOVE   = 4'd2,
        CMD_RANGE    = 4'd3,
        CMD_KEYS     = 4'd4,
        CMD_GET      = 4'd5,
        CMD_MAX      = 4'd6,
        CMD_MIN      = 4'd7,
        CMD_MAXPOS   = 4'd8,
        CMD_MINPOS   = 4'd9,
        CMD_FREQ     = 4'd10,
        CMD_CONTAINS = 4'd11,
        CMD_FIRST    = 4'd12,
        CMD_LAST     = 4'd13,
        CMD_CLEAR    = 4'd14,
        CMD_NONE     = 4'd15
    } cmd_t;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_POS      = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_ARG      = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_STEP,
        S_DONE
    } state_t;

    // Compare unit request and answer
    typedef struct packed {
        logic        want_max;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] key;
    } cmp_req_t;

    typedef struct packed {
        logic better;
        logic equal;
    } cmp_rsp_t;

endpackage

// ----- hdl/indexed_array_table_engine.sv -----
// Packed table of signed 32-bit values with a fill count. One command per
// item, one result per item. Scanning commands (insert, removals, searches)
// walk the stored entries through the entry memory and shared compare
// unit, one entry at a time (read, then compare or move); update, clear and
// argument errors skip the walk, and get reads a single entry. A result
// waits in S_DONE until m_tready takes it. The block takes one item at a
// time; s_tready is high only while idle. There is no clearing pass at reset.
module indexed_array_table_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tuser: kind[3:0]
    input  logic [3:0]  s_tuser,
    // tdata: value[31:0], index[37:32], index_end[43:38], zero[47:44]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: status[2:0], data[34:3], position[40:35], match_count[47:41],
    // found[48], fill[55:49]
    output logic [55:0] m_tdata
);
    import iate_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    state_t state_reg, state_next;
    logic [CW-1:0] used_reg, used_next;
    cmd_t          cmd_reg, cmd_next;
    logic [31:0]   val_reg, val_next;
    logic [CW-1:0] idx_reg, idx_next, iend_reg, iend_next;
    // i: read pointer, w: write pointer, best: extreme or match position
    logic [CW-1:0] i_reg, i_next, w_reg, w_next, best_reg, best_next;
    logic [31:0]   bval_reg, bval_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          hit_reg, hit_next;
    logic [2:0]    st_reg, st_next;
    logic [55:0]   out_reg, out_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata, rdata;
    cmp_req_t      creq;
    cmp_rsp_t      crsp;

    iate_mem #(.AW(AW)) u_mem (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );
    iate_cmp u_cmp (.req(creq), .rsp(crsp));

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_DONE);
    assign m_tdata  = out_reg;
    assign creq.want_max = (cmd_reg == CMD_MAX) || (cmd_reg == CMD_MAXPOS);
    assign creq.a   = rdata;
    assign creq.b   = bval_reg;
    assign creq.key = val_reg;

    // Control and payload registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
        end
        cmd_reg <= cmd_next;   val_reg <= val_next;
        idx_reg <= idx_next;   iend_reg <= iend_next;
        i_reg <= i_next;       w_reg <= w_next;
        best_reg <= best_next; bval_reg <= bval_next;
        cnt_reg <= cnt_next;   hit_reg <= hit_next;
        st_reg <= st_next;
        out_reg <= out_next;
    end

    // Sequencer
    always_comb begin
        logic [CW-1:0] pos_o, cnt_o;
        logic [31:0]   data_o;
        logic          is_ext;
        state_next = state_reg; used_next = used_reg;
        cmd_next = cmd_reg; val_next = val_reg; idx_next = idx_reg;
        iend_next = iend_reg; i_next = i_reg; w_next = w_reg;
        best_next = best_reg; bval_next = bval_reg; cnt_next = cnt_reg;
        hit_next = hit_reg; st_next = st_reg;
        out_next = out_reg;
        we = 1'b0; waddr = w_reg[AW-1:0]; wdata = rdata;
        raddr = i_reg[AW-1:0];
        pos_o = '0; cnt_o = '0; data_o = '0;
        is_ext = (cmd_reg == CMD_MAX) || (cmd_reg == CMD_MIN) ||
                 (cmd_reg == CMD_MAXPOS) || (cmd_reg == CMD_MINPOS);
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next  = cmd_t'(s_tuser);
                    val_next  = s_tdata[31:0];
                    idx_next  = CW'(s_tdata[37:32]);
                    iend_next = CW'(s_tdata[43:38]);
                    cnt_next = '0; hit_next = 1'b0;
                    st_next = ST_OK;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                // Check arguments and set up the walk
                state_next = S_DONE;
                priority case (cmd_reg)
                    CMD_INSERT: begin
                        if (idx_reg > used_reg) st_next = ST_POS;
                        else if (used_reg >= CW'(DEPTH)) st_next = ST_FULL;
                        else begin
                            // move up from the top: read i-1, write i
                            i_next = used_reg;
                            state_next = S_WAIT;
                        end
                    end
                    CMD_UPDATE, CMD_REMOVE, CMD_GET: begin
                        if (used_reg == '0) st_next = ST_EMPTY;
                        else if (idx_reg >= used_reg) st_next = ST_POS;
                        else if (cmd_reg == CMD_UPDATE) begin
                            we = 1'b1; waddr = idx_reg[AW-1:0]; wdata = val_reg;
                        end else if (cmd_reg == CMD_GET) begin
                            i_next = idx_reg; state_next = S_WAIT;
                        end else begin
                            w_next = idx_reg; i_next = idx_reg + 1'b1;
                            used_next = used_reg - 1'b1;
                            state_next = S_WAIT;
                        end
                    end
                    CMD_RANGE: begin
                        if (idx_reg > iend_reg) st_next = ST_ARG;
                        else if (iend_reg >= used_reg) st_next = ST_POS;
                        else begin
                            w_next = idx_reg; i_next = iend_reg + 1'b1;
                            used_next = used_reg - (iend_reg - idx_reg) - 1'b1;
                            state_next = S_WAIT;
                        end
                    end
                    CMD_CLEAR: used_next = '0;
                    CMD_NONE: st_next = ST_EMPTY;
                    default: begin
                        if (used_reg == '0) st_next = ST_EMPTY;
                        else begin
                            if (cmd_reg == CMD_FIRST || cmd_reg == CMD_LAST)
                                st_next = ST_NOTFOUND;
                            i_next = (cmd_reg == CMD_LAST) ? used_reg - 1'b1 : '0;
                            w_next = '0; best_next = '0;
                            state_next = S_WAIT;
                        end
                    end
                endcase
            end
            S_WAIT: begin
                // Issue the read of the current entry, or finish once the walk is done
                if (cmd_reg == CMD_INSERT) begin
                    if (i_reg == idx_reg) begin
                        we = 1'b1; waddr = idx_reg[AW-1:0]; wdata = val_reg;
                        used_next = used_reg + 1'b1;
                        state_next = S_DONE;
                    end else begin
                        raddr = AW'(i_reg - 1'b1);
                        state_next = S_STEP;
                    end
                end else if ((cmd_reg == CMD_REMOVE || cmd_reg == CMD_RANGE) &&
                             w_reg >= used_reg) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_STEP;
                end
            end
            S_STEP: begin
                state_next = S_WAIT;
                unique case (cmd_reg)
                    CMD_INSERT: begin
                        we = 1'b1; waddr = i_reg[AW-1:0];
                        i_next = i_reg - 1'b1;
                    end
                    CMD_REMOVE, CMD_RANGE: begin
                        we = 1'b1; w_next = w_reg + 1'b1; i_next = i_reg + 1'b1;
                    end
                    CMD_GET: begin
                        bval_next = rdata; state_next = S_DONE;
                    end
                    CMD_KEYS: begin
                        if (!crsp.equal) begin
                            we = 1'b1; w_next = w_reg + 1'b1;
                        end
                        i_next = i_reg + 1'b1;
                        if (i_reg + 1'b1 >= used_reg) begin
                            used_next = crsp.equal ? w_reg : w_reg + 1'b1;
                            state_next = S_DONE;
                        end
                    end
                    CMD_LAST: begin
                        if (crsp.equal) begin
                            best_next = i_reg; st_next = ST_OK;
                            state_next = S_DONE;
                        end else if (i_reg == '0) state_next = S_DONE;
                        i_next = i_reg - 1'b1;
                    end
                    default: begin
                        if (is_ext) begin
                            if (i_reg == '0 || crsp.better) begin
                                best_next = i_reg; bval_next = rdata;
                            end
                        end else if (crsp.equal) begin
                            cnt_next = cnt_reg + 1'b1; hit_next = 1'b1;
                            if (cmd_reg == CMD_FIRST) begin
                                best_next = i_reg; st_next = ST_OK;
                                state_next = S_DONE;
                            end
                        end
                        i_next = i_reg + 1'b1;
                        if (i_reg + 1'b1 >= used_reg) state_next = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                if (m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        // Build the result item when leaving the work states
        if (state_next == S_DONE && state_reg != S_DONE) begin
            if (st_next == ST_OK || st_next == ST_NOTFOUND) begin
                if (cmd_reg == CMD_GET || cmd_reg == CMD_MAX || cmd_reg == CMD_MIN)
                    data_o = bval_next;
                if (cmd_reg == CMD_MAXPOS || cmd_reg == CMD_MINPOS ||
                    cmd_reg == CMD_FIRST || cmd_reg == CMD_LAST)
                    pos_o = best_next;
                if (cmd_reg == CMD_FREQ) cnt_o = cnt_next;
            end
            if (st_next == ST_NOTFOUND) pos_o = '0;
            out_next = {7'(used_next),
                        (cmd_reg == CMD_CONTAINS) && hit_next && st_next == ST_OK,
                        7'(cnt_o), 6'(pos_o), data_o, st_next};
        end
    end
endmodule

// ----- hdl/iate_cmp.sv -----
// Shared compare unit: signed better-than and equality against the key.
// Depends on iate_pkg.
module iate_cmp (
    input  iate_pkg::cmp_req_t req,
    output iate_pkg::cmp_rsp_t rsp
);
    import iate_pkg::*;

    // Signed order and key match
    always_comb begin
        rsp.better = req.want_max ? ($signed(req.a) > $signed(req.b))
                                  : ($signed(req.a) < $signed(req.b));
        rsp.equal  = (req.a == req.key);
    end
endmodule

// ----- hdl/iate_mem.sv -----
// Entry store: one write port, one registered read port.
// Depends on nothing.
module iate_mem #(
    parameter int AW = 6
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);
    logic [31:0] mem [2**AW];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/iate_checker.sv -----
// Port-level checker for the table engine, bound to the top level.
// Depends on iate_pkg for status codes.
module iate_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] s_tdata,
    input logic [55:0] m_tdata
);
    import iate_pkg::*;

    // Never take an item while a result is pending
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("ready while result pending");

    // A result holds until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");

    // Status code stays within the defined set
    a_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= ST_FULL) else $error("bad status");

    // Accepted item leads to busy next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("ready after accept");
endmodule

bind indexed_array_table_engine iate_checker u_iate_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .s_tdata(s_tdata), .m_tdata(m_tdata)
);

// ----- tb/tb_checker.sv -----
// Checker for the indexed array table engine: watches both stream channels,
// predicts each result from its own copy of the table and compares it.
// Depends on iate_pkg.
`timescale 1ns / 1ps

module tb_checker
    import iate_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [3:0]  s_tuser,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [6:0]  fill;
        logic        found;
        logic [6:0]  match_count;
        logic [5:0]  position;
        logic [31:0] data;
        logic [2:0]  status;
    } table_result_t;

    logic signed [31:0] shadow [DEPTH];
    int                 shadow_fill;
    table_result_t      expected_results [$];

    assign pending = expected_results.size();

    // Apply one command to the shadow table and return its result
    function automatic table_result_t apply_command(logic [3:0] kind_bits,
                                                    logic [47:0] word);
        cmd_t               kind;
        logic signed [31:0] val;
        int                 idx;
        int                 idx_end;
        int                 best;
        int                 w;
        int                 span;
        table_result_t      r;
        kind    = cmd_t'(kind_bits);
        val     = word[31:0];
        idx     = word[37:32];
        idx_end = word[43:38];
        r       = '0;
        r.status = ST_OK;
        case (kind)
            CMD_INSERT: begin
                if (idx > shadow_fill) r.status = ST_POS;
                else if (shadow_fill >= DEPTH) r.status = ST_FULL;
                else begin
                    for (int i = shadow_fill; i > idx; i--) shadow[i] = shadow[i-1];
                    shadow[idx] = val;
                    shadow_fill++;
                end
            end
            CMD_UPDATE, CMD_REMOVE, CMD_GET: begin
                if (shadow_fill == 0) r.status = ST_EMPTY;
                else if (idx >= shadow_fill) r.status = ST_POS;
                else if (kind == CMD_UPDATE) shadow[idx] = val;
                else if (kind == CMD_GET) r.data = shadow[idx];
                else begin
                    for (int j = idx + 1; j < shadow_fill; j++) shadow[j-1] = shadow[j];
                    shadow_fill--;
                end
            end
            CMD_RANGE: begin
                if (idx > idx_end) r.status = ST_ARG;
                else if (idx_end >= shadow_fill) r.status = ST_POS;
                else begin
                    span = idx_end - idx + 1;
                    for (int j = idx_end + 1; j < shadow_fill; j++)
                        shadow[j-span] = shadow[j];
                    shadow_fill -= span;
                end
            end
            CMD_CLEAR: shadow_fill = 0;
            CMD_NONE:  r.status = ST_EMPTY;
            default: begin
                if (shadow_fill == 0) r.status = ST_EMPTY;
                else if (kind == CMD_KEYS) begin
                    w = 0;
                    for (int i = 0; i < shadow_fill; i++)
                        if (shadow[i] != val) begin
                            shadow[w] = shadow[i];
                            w++;
                        end
                    shadow_fill = w;
                end else if (kind inside {CMD_MAX, CMD_MIN, CMD_MAXPOS, CMD_MINPOS}) begin
                    best = 0;
                    for (int i = 1; i < shadow_fill; i++)
                        if ((kind == CMD_MAX || kind == CMD_MAXPOS) ?
                            (shadow[i] > shadow[best]) : (shadow[i] < shadow[best]))
                            best = i;
                    if (kind == CMD_MAX || kind == CMD_MIN) r.data = shadow[best];
                    else r.position = 6'(best);
                end else if (kind == CMD_FREQ) begin
                    for (int i = 0; i < shadow_fill; i++)
                        if (shadow[i] == val) r.match_count++;
                end else if (kind == CMD_CONTAINS) begin
                    for (int i = 0; i < shadow_fill; i++)
                        if (shadow[i] == val) r.found = 1'b1;
                end else if (kind == CMD_FIRST) begin
                    r.status = ST_NOTFOUND;
                    for (int i = shadow_fill - 1; i >= 0; i--)
                        if (shadow[i] == val) begin
                            r.status = ST_OK;
                            r.position = 6'(i);
                        end
                end else begin
                    r.status = ST_NOTFOUND;
                    for (int i = 0; i < shadow_fill; i++)
                        if (shadow[i] == val) begin
                            r.status = ST_OK;
                            r.position = 6'(i);
                        end
                end
            end
        endcase
        r.fill = shadow_fill[6:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Predict on each accepted input item, compare each accepted result
    always @(posedge aclk) begin
        table_result_t got;
        table_result_t want;
        if (!aresetn) begin
            shadow_fill <= 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_command(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_results.size() == 0) begin
                    $display("%0t: result with no item outstanding", $realtime);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.data != want.data) report_mismatch("data", got.data, want.data);
                    if (got.position != want.position)
                        report_mismatch("position", got.position, want.position);
                    if (got.match_count != want.match_count)
                        report_mismatch("match_count", got.match_count, want.match_count);
                    if (got.found != want.found) report_mismatch("found", got.found, want.found);
                    if (got.fill != want.fill) report_mismatch("fill", got.fill, want.fill);
                end
            end
        end
    end

    initial fail_count = 0;

endmodule

// ----- tb/tb.sv -----
// Top of the indexed array table engine testbench: clock, reset, command
// stimulus, result back-pressure and verdict. Depends on iate_pkg, the block
// and tb_checker.
`timescale 1ns / 1ps

module tb;
    import iate_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [3:0]  s_tuser;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    int          fail_count;
    int          pending;
    int          cycle_count;
    int          model_fill;
    bit          hold_results;
    logic [31:0] recent_values [8];

    indexed_array_table_engine u_top (.*);

    tb_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Bound the run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 95) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Pick values from a small pool often so that searches hit
    function automatic logic [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6) return recent_values[$urandom_range(0, 7)];
        if (roll == 6) return {1'b1, 31'd0};
        if (roll == 7) return {1'b0, {31{1'b1}}};
        return $urandom();
    endfunction

    task automatic send_item(cmd_t kind, logic [31:0] value, logic [5:0] idx,
                             logic [5:0] idx_end);
        int gap;
        gap = gap_length();
        repeat (gap) @(negedge aclk);
        s_tuser  = kind;
        s_tdata  = {4'd0, idx_end, idx, value};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        s_tvalid = 1'b0;
        // Track the fill roughly to steer the command mix
        case (kind)
            CMD_INSERT: if (idx <= model_fill && model_fill < DEPTH) model_fill++;
            CMD_REMOVE: if (idx < model_fill) model_fill--;
            CMD_RANGE:  if (idx <= idx_end && idx_end < model_fill)
                model_fill -= idx_end - idx + 1;
            CMD_KEYS:   model_fill = u_checker_fill_hint();
            CMD_CLEAR:  model_fill = 0;
            default: ;
        endcase
    endtask

    // Remove keys can change fill by any amount; this keeps the old fill until the main loop learns it
    function automatic int u_checker_fill_hint();
        return model_fill;
    endfunction

    task automatic drain();
        while (pending != 0) @(negedge aclk);
        repeat (2 * DEPTH + 10) @(negedge aclk);
    endtask

    // Result back-pressure, with one long hold-off on request
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_results) begin
                m_tready <= 1'b0;
                repeat (400) @(negedge aclk);
                hold_results = 1'b0;
            end else if (cycle_count % 3000 < 800) begin
                m_tready <= 1'b1;
            end else if ($urandom_range(0, 40) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(20, 80)) @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    initial begin
        int   kind_roll;
        cmd_t kind;
        logic [5:0] idx;
        logic [5:0] idx_end;
        s_tvalid     = 1'b0;
        s_tuser      = '0;
        s_tdata      = '0;
        aresetn      = 1'b0;
        cycle_count  = 0;
        model_fill   = 0;
        hold_results = 1'b0;
        foreach (recent_values[i]) recent_values[i] = $urandom();
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // Empty-table cases
        for (int k = 1; k <= 15; k++) send_item(cmd_t'(k), 32'd5, 6'd0, 6'd0);
        send_item(CMD_INSERT, 32'd1, 6'd1, 6'd0);
        send_item(CMD_RANGE, 32'd0, 6'd3, 6'd2);
        // Extremes, ties and boundary positions
        send_item(CMD_INSERT, {1'b1, 31'd0}, 6'd0, 6'd0);
        send_item(CMD_INSERT, {1'b0, {31{1'b1}}}, 6'd1, 6'd0);
        send_item(CMD_INSERT, {1'b0, {31{1'b1}}}, 6'd0, 6'd0);
        send_item(CMD_INSERT, {1'b1, 31'd0}, 6'd3, 6'd0);
        send_item(CMD_MAXPOS, 32'd0, 6'd0, 6'd0);
        send_item(CMD_MINPOS, 32'd0, 6'd0, 6'd0);
        send_item(CMD_LAST, {1'b1, 31'd0}, 6'd0, 6'd0);
        send_item(CMD_GET, 32'd0, 6'd63, 6'd63);
        model_fill = 4;
        drain();

        // Fill to capacity, hit full, read the top entry, then remove the whole range
        for (int i = 0; i < DEPTH; i++)
            send_item(CMD_INSERT, $urandom(), 6'($urandom_range(0, model_fill)), 6'd0);
        send_item(CMD_INSERT, 32'd7, 6'd0, 6'd0);
        send_item(CMD_GET, 32'd0, 6'd63, 6'd0);
        send_item(CMD_RANGE, 32'd0, 6'd0, 6'd63);

        // Stall the receiver while items keep coming
        hold_results = 1'b1;
        for (int i = 0; i < 8; i++) send_item(CMD_INSERT, pick_value(), 6'd0, 6'd0);

        // Random commands, mostly at valid positions
        for (int n = 0; n < 1000; n++) begin
            if (n % 250 == 249) drain();
            if ($urandom_range(0, 15) == 0) recent_values[$urandom_range(0, 7)] = $urandom();
            kind_roll = $urandom_range(0, 99);
            if (kind_roll < 35 && model_fill < DEPTH) kind = CMD_INSERT;
            else if (kind_roll < 98) kind = cmd_t'($urandom_range(1, 13));
            else kind = cmd_t'($urandom_range(14, 15));
            if ($urandom_range(0, 9) == 0) idx = 6'($urandom());
            else idx = 6'($urandom_range(0, model_fill == 0 ? 0 : model_fill));
            idx_end = ($urandom_range(0, 9) == 0) ? 6'($urandom()) :
                      6'($urandom_range(idx, model_fill == 0 ? 0 :
                                        (idx >= model_fill ? idx : model_fill - 1)));
            if (kind == CMD_RANGE && $urandom_range(0, 1))
                idx_end = 6'(idx + 6'($urandom_range(0, 2)));
            send_item(kind, pick_value(), idx, idx_end);
            if (kind == CMD_KEYS) begin
                // Learn the new fill from the checker's shadow table
                while (pending != 0) @(negedge aclk);
                model_fill = u_checker.shadow_fill;
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
